@@ hdl/awcr_pkg.sv @@
// ----------------------------------------------------------------------------
// awcr_pkg: shared types and constants of the word copy realigner
// Word geometry, result item layout, queue sizing and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package awcr_pkg;

    localparam int unsigned WORD_BYTES = 8;               // bytes per aligned word
    localparam int unsigned BUF_BYTES  = 2 * WORD_BYTES;  // carry plus one source word
    localparam int unsigned DATA_W     = 8 * WORD_BYTES;
    localparam int unsigned IDX_W      = 30;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned CFG_W      = 32;
    localparam int unsigned OFF_W      = $clog2(WORD_BYTES);
    localparam int unsigned NEED_W     = OFF_W + 1;        // 0..WORD_BYTES
    localparam int unsigned POS_W      = NEED_W + 1;       // 0..BUF_BYTES
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_AW       = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam logic [2:0] CFG_MODE       = 3'd0;
    localparam logic [2:0] CFG_SRC_OFFSET = 3'd1;
    localparam logic [2:0] CFG_DST_OFFSET = 3'd2;
    localparam logic [2:0] CFG_BYTE_COUNT = 3'd3;
    localparam logic [2:0] CFG_FILL_BYTE  = 3'd4;

    // mode register values
    localparam logic MODE_COPY = 1'b0;
    localparam logic MODE_FILL = 1'b1;

    typedef logic [BUF_BYTES-1:0][7:0] t_buf;

    typedef struct packed {
        logic [DATA_W-1:0]     dst_word;
        logic [WORD_BYTES-1:0] byte_enable;
        logic [IDX_W-1:0]      word_index;
        logic                  last;
    } t_item;

    // up to two results per request, slot 1 only with slot 0
    typedef struct packed {
        logic  push0;
        logic  push1;
        t_item item0;
        t_item item1;
    } t_push;

endpackage

`default_nettype wire

@@ hdl/aligned_word_copy_realigner_core.sv @@
// ----------------------------------------------------------------------------
// aligned_word_copy_realigner_core: word copy / fill engine with realignment
// Turns aligned source words into aligned destination words with byte enables.
// ----------------------------------------------------------------------------
// Usage:
//   Program mode, offsets, byte count and fill byte through the write port;
//   any write to a known register starts a new transfer. Then send aligned
//   source words on the src channel (valid/stall); in fill mode the words
//   only pace the output. Destination words leave on the dst channel with a
//   byte-enable mask, a word index and a last flag on the final word.
//   One request per cycle while src is not stalled. Each request makes zero,
//   one or two results, computed by 24 byte lanes (two result slots plus the
//   carry). Results show up on dst in the cycle after the request at the
//   earliest and go out one per cycle unless dst stalls, from a 4-entry
//   queue; the src side stalls while three or more results are held, so a
//   stalled receiver backs up to the sender with at most four results queued.
//   Once the byte count is used up, further requests are taken and dropped.
//   Reset clears all registers and the queue; no transfer is armed after
//   reset, and no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module aligned_word_copy_realigner_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [awcr_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire                                i_src_valid,
    output logic                               o_src_stall,
    input  wire logic [awcr_pkg::DATA_W-1:0]   i_src_word,
    output logic                               o_dst_valid,
    input  wire                                i_dst_stall,
    output logic      [awcr_pkg::DATA_W-1:0]   o_dst_word,
    output logic      [awcr_pkg::WORD_BYTES-1:0] o_byte_enable,
    output logic      [awcr_pkg::IDX_W-1:0]    o_word_index,
    output logic                               o_last
);

    localparam int unsigned WB  = awcr_pkg::WORD_BYTES;
    localparam int unsigned OW  = awcr_pkg::OFF_W;
    localparam int unsigned NW  = awcr_pkg::NEED_W;
    localparam int unsigned PW  = awcr_pkg::POS_W;
    localparam int unsigned CW  = awcr_pkg::CNT_W;
    localparam logic [NW-1:0] FULL_NEED = NW'(WB);

    // configuration
    logic            r_mode;
    logic [OW-1:0]   r_src_offset;
    logic [OW-1:0]   r_dst_offset;
    logic [CW-1:0]   r_byte_count;
    logic [7:0]      r_fill_byte;

    // transfer state
    logic [WB-1:0][7:0]           r_carry;
    logic [NW-1:0]                r_carry_bytes;
    logic [CW-1:0]                r_bytes_left;
    logic [awcr_pkg::IDX_W-1:0]   r_out_cnt;
    logic                         r_first_word;
    logic                         r_src_first;

    logic            w_cfg_hit;
    logic            w_acc;
    logic            w_busy;
    awcr_pkg::t_buf  w_buf;
    logic [PW-1:0]   w_nt;
    logic [OW-1:0]   w_in_start;
    logic [NW-1:0]   w_in_cnt;
    logic [WB-1:0][7:0] w_in_bytes;

    logic [OW-1:0]   w_off0;
    logic [NW-1:0]   w_room0;
    logic [NW-1:0]   w_need0;
    logic [NW-1:0]   w_need1;
    logic [CW-1:0]   w_left1;
    logic [CW-1:0]   w_left2;
    logic [CW-1:0]   w_left_fin;
    logic            w_ok0;
    logic            w_ok1;
    logic [PW-1:0]   w_pos;
    logic [PW-1:0]   w_rem;
    logic [NW-1:0]   w_keep;

    logic [WB-1:0][7:0] w_data0;
    logic [WB-1:0][7:0] w_data1;
    logic [WB-1:0][7:0] w_carry_next;
    logic [WB-1:0]      w_be0;
    logic [WB-1:0]      w_be1;
    logic [WB-1:0]      w_carry_en;

    awcr_pkg::t_push w_push;
    awcr_pkg::t_item w_out;
    logic            w_q_full2;

    assign w_in_bytes = i_src_word;
    assign w_acc      = i_src_valid && !o_src_stall;
    assign w_busy     = (r_bytes_left != '0);
    assign o_src_stall = w_q_full2;

    always_comb begin
        unique case (i_cfg_index)
            awcr_pkg::CFG_MODE,
            awcr_pkg::CFG_SRC_OFFSET,
            awcr_pkg::CFG_DST_OFFSET,
            awcr_pkg::CFG_BYTE_COUNT,
            awcr_pkg::CFG_FILL_BYTE: w_cfg_hit = i_cfg_we;
            default:                 w_cfg_hit = 1'b0;
        endcase
    end

    // staging buffer: carry bytes, then the new source bytes from the start offset (fill byte throughout in fill mode)
    always_comb begin
        logic [PW-1:0] k;
        w_in_start = r_src_first ? r_src_offset : '0;
        w_in_cnt   = FULL_NEED - {1'b0, w_in_start};
        for (int i = 0; i < awcr_pkg::BUF_BYTES; i++) begin
            k = PW'(i) - {1'b0, r_carry_bytes};
            if (r_mode == awcr_pkg::MODE_FILL) begin
                w_buf[i] = r_fill_byte;
            end else if (PW'(i) < {1'b0, r_carry_bytes}) begin
                w_buf[i] = r_carry[OW'(i)];
            end else if (k < {1'b0, w_in_cnt}) begin
                w_buf[i] = w_in_bytes[k[OW-1:0] + w_in_start];
            end else begin
                w_buf[i] = 8'd0;
            end
        end
        if (r_mode == awcr_pkg::MODE_FILL) begin
            w_nt = PW'(awcr_pkg::BUF_BYTES);
        end else begin
            w_nt = {1'b0, r_carry_bytes} + {1'b0, w_in_cnt};
        end
    end

    // slot sizes and which slots fire
    always_comb begin
        w_off0  = r_first_word ? r_dst_offset : '0;
        w_room0 = FULL_NEED - {1'b0, w_off0};
        w_need0 = (r_bytes_left < CW'(w_room0)) ? r_bytes_left[NW-1:0] : w_room0;
        w_ok0   = w_busy && ({1'b0, w_need0} <= w_nt);
        w_left1 = r_bytes_left - CW'(w_need0);
        w_need1 = (w_left1 < CW'(WB)) ? w_left1[NW-1:0] : FULL_NEED;
        w_ok1   = (r_mode == awcr_pkg::MODE_COPY) && w_ok0 && (w_left1 != '0)
                  && (({1'b0, w_need0} + {1'b0, w_need1}) <= w_nt);
        w_left2 = w_left1 - CW'(w_need1);
        priority if (w_ok1) begin
            w_left_fin = w_left2;
        end else if (w_ok0) begin
            w_left_fin = w_left1;
        end else begin
            w_left_fin = r_bytes_left;
        end
        w_pos = (w_ok0 ? {1'b0, w_need0} : '0) + (w_ok1 ? {1'b0, w_need1} : '0);
        w_rem = w_nt - w_pos;
        w_keep = (w_rem > PW'(WB)) ? FULL_NEED : w_rem[NW-1:0];
    end

    for (genvar j = 0; j < WB; j++) begin : g_lane
        awcr_lane #(.LANE(j)) u_slot0 (
            .i_buf   (w_buf),
            .i_start ('0),
            .i_off   (w_off0),
            .i_need  (w_need0),
            .o_byte  (w_data0[j]),
            .o_en    (w_be0[j])
        );
        awcr_lane #(.LANE(j)) u_slot1 (
            .i_buf   (w_buf),
            .i_start ({1'b0, w_need0}),
            .i_off   ('0),
            .i_need  (w_need1),
            .o_byte  (w_data1[j]),
            .o_en    (w_be1[j])
        );
        awcr_lane #(.LANE(j)) u_carry (
            .i_buf   (w_buf),
            .i_start (w_pos),
            .i_off   ('0),
            .i_need  (w_keep),
            .o_byte  (w_carry_next[j]),
            .o_en    (w_carry_en[j])
        );
    end

    // merge lane outputs into queue writes
    always_comb begin
        w_push.push0            = w_acc && w_ok0;
        w_push.push1            = w_acc && w_ok1;
        w_push.item0.dst_word   = w_data0;
        w_push.item0.byte_enable = w_be0;
        w_push.item0.word_index = r_out_cnt;
        w_push.item0.last       = (w_left1 == '0);
        w_push.item1.dst_word   = w_data1;
        w_push.item1.byte_enable = w_be1;
        w_push.item1.word_index = r_out_cnt + 1'b1;
        w_push.item1.last       = (w_left2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= awcr_pkg::MODE_COPY;
            r_src_offset  <= '0;
            r_dst_offset  <= '0;
            r_byte_count  <= '0;
            r_fill_byte   <= '0;
            r_carry       <= '0;
            r_carry_bytes <= '0;
            r_bytes_left  <= '0;
            r_out_cnt     <= '0;
            r_first_word  <= 1'b1;
            r_src_first   <= 1'b1;
        end else if (w_cfg_hit) begin
            unique case (i_cfg_index)
                awcr_pkg::CFG_MODE:       r_mode       <= i_cfg_data[0];
                awcr_pkg::CFG_SRC_OFFSET: r_src_offset <= i_cfg_data[OW-1:0];
                awcr_pkg::CFG_DST_OFFSET: r_dst_offset <= i_cfg_data[OW-1:0];
                awcr_pkg::CFG_BYTE_COUNT: r_byte_count <= i_cfg_data[CW-1:0];
                awcr_pkg::CFG_FILL_BYTE:  r_fill_byte  <= i_cfg_data[7:0];
                default: ;
            endcase
            r_carry       <= '0;
            r_carry_bytes <= '0;
            r_out_cnt     <= '0;
            r_first_word  <= 1'b1;
            r_src_first   <= 1'b1;
            r_bytes_left  <= (i_cfg_index == awcr_pkg::CFG_BYTE_COUNT)
                             ? i_cfg_data[CW-1:0] : r_byte_count;
        end else if (w_acc && w_busy) begin
            r_bytes_left <= w_left_fin;
            r_out_cnt    <= r_out_cnt + awcr_pkg::IDX_W'(w_ok0) + awcr_pkg::IDX_W'(w_ok1);
            if (w_ok0) begin
                r_first_word <= 1'b0;
            end
            if (r_mode == awcr_pkg::MODE_COPY) begin
                r_src_first <= 1'b0;
                if (w_left_fin == '0) begin
                    r_carry       <= '0;
                    r_carry_bytes <= '0;
                end else begin
                    r_carry       <= w_carry_next;
                    r_carry_bytes <= w_keep;
                end
            end
        end
    end

    awcr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full2 (w_q_full2),
        .o_valid (o_dst_valid),
        .i_stall (i_dst_stall),
        .o_item  (w_out)
    );

    assign o_dst_word    = w_out.dst_word;
    assign o_byte_enable = w_out.byte_enable;
    assign o_word_index  = w_out.word_index;
    assign o_last        = w_out.last;

    // second slot never fires alone
    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push1 |-> w_push.push0)
        else $error("second result without first");

    // every emitted word consumes bytes
    a_bytes_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.push0 && !w_cfg_hit) |=> (r_bytes_left < $past(r_bytes_left)))
        else $error("result without byte count progress");

    // a register write rearms the transfer
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> (r_first_word && r_src_first && r_carry_bytes == '0
                       && r_out_cnt == '0))
        else $error("transfer not rearmed after register write");

    // queue never holds more than its room allows before a request
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full2 |-> !w_push.push0)
        else $error("result pushed while queue short of room");

    // kept carry bytes always sit in the low lanes
    a_carry_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_carry_en & (w_carry_en + 1'b1)) == '0)
        else $error("carry lanes not packed low");

endmodule

`default_nettype wire

@@ hdl/awcr_lane.sv @@
// ----------------------------------------------------------------------------
// awcr_lane: one destination byte lane
// Picks the byte for a fixed lane position out of the staging buffer, given
// the window start in the buffer, the first enabled lane and the byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module awcr_lane #(
    parameter int unsigned LANE = 0
) (
    input  wire awcr_pkg::t_buf                i_buf,
    input  wire logic [awcr_pkg::POS_W-1:0]    i_start,
    input  wire logic [awcr_pkg::OFF_W-1:0]    i_off,
    input  wire logic [awcr_pkg::NEED_W-1:0]   i_need,
    output logic      [7:0]                    o_byte,
    output logic                               o_en
);

    localparam logic [awcr_pkg::NEED_W-1:0] LANE_POS = awcr_pkg::NEED_W'(LANE);

    logic [awcr_pkg::NEED_W-1:0] w_rel;
    logic [awcr_pkg::POS_W-1:0]  w_idx;

    always_comb begin
        w_rel  = LANE_POS - {1'b0, i_off};
        w_idx  = i_start + {1'b0, w_rel};
        o_en   = (LANE_POS >= {1'b0, i_off}) && (w_rel < i_need);
        o_byte = o_en ? i_buf[w_idx[awcr_pkg::POS_W-2:0]] : 8'd0;
    end

endmodule

`default_nettype wire

@@ hdl/awcr_outq.sv @@
// ----------------------------------------------------------------------------
// awcr_outq: result queue
// Small queue taking up to two results a cycle and giving one unless
// stalled; it pushes back on the request side when under two entries are free.
// ----------------------------------------------------------------------------
`default_nettype none

module awcr_outq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire awcr_pkg::t_push i_push,
    output logic                 o_full2,
    output logic                 o_valid,
    input  wire                  i_stall,
    output awcr_pkg::t_item      o_item
);

    awcr_pkg::t_item r_mem [awcr_pkg::Q_DEPTH];

    logic [awcr_pkg::Q_AW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [awcr_pkg::Q_AW:0]   r_cnt, n_cnt;
    logic                      w_pop;
    logic [awcr_pkg::Q_AW-1:0] w_wr1;
    logic [1:0]                w_npush;

    assign w_pop   = o_valid && !i_stall;
    assign w_wr1   = r_wr + 1'b1;
    assign w_npush = {1'b0, i_push.push0} + {1'b0, i_push.push1};
    assign o_valid = (r_cnt != '0);
    assign o_full2 = (r_cnt > (awcr_pkg::Q_AW + 1)'(awcr_pkg::Q_DEPTH - 2));
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr + awcr_pkg::Q_AW'(w_npush);
        n_rd  = r_rd + awcr_pkg::Q_AW'(w_pop);
        n_cnt = r_cnt + (awcr_pkg::Q_AW + 1)'(w_npush) - (awcr_pkg::Q_AW + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_push.item0;
        end
        if (i_push.push1) begin
            r_mem[w_wr1] <= i_push.item1;
        end
    end

endmodule

`default_nettype wire
